// ===== design/prq_pkg.sv =====
// Shared constants and control types for the priority ready queue.
package prq_pkg;

  localparam int CAPACITY_DEF      = 256;
  localparam int PRIORITY_BITS_DEF = 8;

  localparam int ID_W      = 8;
  localparam int IN_PRIO_W = 8;
  localparam int OCC_W     = 9;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 2;

  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic scan;
    logic shift_init;
    logic shift;
    logic finish;
  } prq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_remove;
    logic empty;
    logic sweep_done;
    logic out_free;
  } prq_status_t;

endpackage

// ===== design/prq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module prq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/prq_ctrl.sv =====
// Controller state machine for the priority ready queue.
module prq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  prq_pkg::prq_status_t status,
  output prq_pkg::prq_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_SHIFT  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          // A remove from a non-empty queue needs a scan; all else commits at once.
          if (status.in_remove && !status.empty) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.sweep_done) begin
          cmd.shift_init = 1'b1;
          state_nxt      = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
        if (status.sweep_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/prq_datapath.sv =====
// Datapath of the priority ready queue: entry store, scan, shift and result register.
module prq_datapath #(
  parameter int CAPACITY      = prq_pkg::CAPACITY_DEF,
  parameter int PRIORITY_BITS = prq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [prq_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [0:0]                       in_tuser,
  input  prq_pkg::prq_cmd_t                cmd,
  output prq_pkg::prq_status_t             status,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [prq_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [prq_pkg::OUT_TUSER_W-1:0]  out_tuser
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = PRIORITY_BITS;
  localparam int IW = prq_pkg::ID_W;
  localparam int DW = IW + PW;

  // Request latched at acceptance.
  logic          req_remove_r, req_remove_nxt;
  logic [IW-1:0] req_id_r, req_id_nxt;
  logic [PW-1:0] req_prio_r, req_prio_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] addr_r, addr_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_idx_r, pend_idx_nxt;

  logic [AW-1:0] best_idx_r, best_idx_nxt;
  logic [PW-1:0] best_prio_r, best_prio_nxt;
  logic [IW-1:0] best_id_r, best_id_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic                      out_found_r, out_found_nxt;
  logic                      out_rejected_r, out_rejected_nxt;
  logic [IW-1:0]             out_id_r, out_id_nxt;
  logic [prq_pkg::IN_PRIO_W-1:0] out_prio_r, out_prio_nxt;
  logic [prq_pkg::OCC_W-1:0] out_occ_r, out_occ_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;
  logic [PW-1:0] rd_prio;
  logic [IW-1:0] rd_id;

  logic addr_lt_count, empty, full, take_entry, commit_add;

  assign addr_lt_count = (addr_r < count_r);
  assign empty         = (count_r == '0);
  assign full          = (count_r == CW'(CAPACITY));
  assign rd_prio       = ram_rdata[DW-1:IW];
  assign rd_id         = ram_rdata[IW-1:0];
  assign take_entry    = req_remove_r && !empty;
  assign commit_add    = (req_remove_r == prq_pkg::REQ_ADD) && !full;

  assign status.in_remove  = (in_tuser[0] == prq_pkg::REQ_REMOVE);
  assign status.empty      = empty;
  assign status.sweep_done = !addr_lt_count && !pend_r;
  assign status.out_free   = !out_valid_r || out_tready;

  // One read a cycle during scan and shift; a shift writes the entry read
  // last cycle one slot lower, an add writes at the tail on commit.
  assign ram_re    = (cmd.scan || cmd.shift) && addr_lt_count;
  assign ram_raddr = addr_r[AW-1:0];
  assign ram_we    = (cmd.shift && pend_r) || (cmd.finish && commit_add);
  assign ram_waddr = cmd.shift ? (pend_idx_r - AW'(1)) : count_r[AW-1:0];
  assign ram_wdata = cmd.shift ? ram_rdata : {req_prio_r, req_id_r};

  prq_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    req_remove_nxt   = req_remove_r;
    req_id_nxt       = req_id_r;
    req_prio_nxt     = req_prio_r;
    count_nxt        = count_r;
    addr_nxt         = addr_r;
    pend_nxt         = pend_r;
    pend_idx_nxt     = pend_idx_r;
    best_idx_nxt     = best_idx_r;
    best_prio_nxt    = best_prio_r;
    best_id_nxt      = best_id_r;
    out_valid_nxt    = out_valid_r;
    out_found_nxt    = out_found_r;
    out_rejected_nxt = out_rejected_r;
    out_id_nxt       = out_id_r;
    out_prio_nxt     = out_prio_r;
    out_occ_nxt      = out_occ_r;

    if (cmd.start) begin
      req_remove_nxt = in_tuser[0];
      req_id_nxt     = in_tdata[IW-1:0];
      req_prio_nxt   = PW'(in_tdata[IW +: prq_pkg::IN_PRIO_W]);
      addr_nxt       = '0;
      pend_nxt       = 1'b0;
    end

    if (cmd.scan || cmd.shift) begin
      pend_nxt     = addr_lt_count;
      pend_idx_nxt = addr_r[AW-1:0];
      if (addr_lt_count) begin
        addr_nxt = addr_r + CW'(1);
      end
    end

    // Strictly greater keeps the earliest entry on equal priority.
    if (cmd.scan && pend_r) begin
      if ((pend_idx_r == '0) || (rd_prio > best_prio_r)) begin
        best_idx_nxt  = pend_idx_r;
        best_prio_nxt = rd_prio;
        best_id_nxt   = rd_id;
      end
    end

    if (cmd.shift_init) begin
      addr_nxt = CW'(best_idx_r) + CW'(1);
      pend_nxt = 1'b0;
    end

    if (cmd.finish) begin
      if (take_entry) begin
        count_nxt = count_r - CW'(1);
      end else if (commit_add) begin
        count_nxt = count_r + CW'(1);
      end
      out_valid_nxt    = 1'b1;
      out_found_nxt    = take_entry;
      out_rejected_nxt = !req_remove_r && full;
      out_id_nxt       = take_entry ? best_id_r : '0;
      out_prio_nxt     = take_entry ? prq_pkg::IN_PRIO_W'(best_prio_r) : '0;
      out_occ_nxt      = prq_pkg::OCC_W'(count_nxt);
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_remove_r   <= req_remove_nxt;
    req_id_r       <= req_id_nxt;
    req_prio_r     <= req_prio_nxt;
    addr_r         <= addr_nxt;
    pend_idx_r     <= pend_idx_nxt;
    best_idx_r     <= best_idx_nxt;
    best_prio_r    <= best_prio_nxt;
    best_id_r      <= best_id_nxt;
    out_found_r    <= out_found_nxt;
    out_rejected_r <= out_rejected_nxt;
    out_id_r       <= out_id_nxt;
    out_prio_r     <= out_prio_nxt;
    out_occ_r      <= out_occ_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_occ_r, out_prio_r, out_id_r};
  assign out_tuser  = {out_rejected_r, out_found_r};

endmodule

// ===== design/priority_ready_queue_top.sv =====
// Top level of the priority ready queue: controller plus datapath.
//
//   Channel  Direction  Handshake              Payload
//   in_      slave      in_tvalid/in_tready    tdata: entry_id, entry_priority; tuser: req_type
//   out_     master     out_tvalid/out_tready  tdata: out_id, out_priority, occupancy;
//                                              tuser: found, rejected
//
// An add is committed without a scan of the entry store. A remove sweeps the single
// read port of the entry store once to find the best entry and once more to close the
// gap behind it.
// Reset: rst_n is synchronous and active low; it empties the queue and drops any
// pending result beat. The entry store itself is not cleared.
// Stalls: the result register holds one beat; a new request is taken while it waits,
// and the block holds its next result until out_tready frees the register.
//
// Entries are kept in arrival order. A remove returns the entry with the greatest
// priority, the earliest one on a tie. An add to a full queue is dropped and flagged
// as rejected. Every beat reports the number of entries held after the request.
module priority_ready_queue_top #(
  parameter int CAPACITY      = prq_pkg::CAPACITY_DEF,
  parameter int PRIORITY_BITS = prq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [prq_pkg::IN_TDATA_W-1:0]  in_tdata,   // [7:0] entry_id, [15:8] entry_priority
  input  logic [0:0]                      in_tuser,   // [0] req_type
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [prq_pkg::OUT_TDATA_W-1:0] out_tdata,  // [7:0] out_id, [15:8] out_priority,
                                                      // [24:16] occupancy, rest zero
  output logic [prq_pkg::OUT_TUSER_W-1:0] out_tuser   // [0] found, [1] rejected
);

  prq_pkg::prq_cmd_t    cmd;
  prq_pkg::prq_status_t status;

  // The controller sequences accept, scan, shift and commit.
  prq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath owns the entry store, the count and the result register.
  prq_datapath #(
    .CAPACITY      (CAPACITY),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== design/prq_checker.sv =====
// Port-level assertions for the priority ready queue, bound to the top level.
module prq_checker #(
  parameter int CAPACITY = prq_pkg::CAPACITY_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [prq_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [prq_pkg::OUT_TUSER_W-1:0] out_tuser
);

  // One request at a time: the input is closed in the cycle after a beat is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input stayed open after a request beat");

  a_found_xor_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("result beat is both found and rejected");

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[15:0] == 16'h0000)
    else $error("result without an entry carries a nonzero id or priority");

  a_reject_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata[24:16] == prq_pkg::OCC_W'(CAPACITY))
    else $error("rejected add reports an occupancy other than full");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed");

endmodule

bind priority_ready_queue_top prq_checker #(
  .CAPACITY (CAPACITY)
) u_prq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
